### rtl/msp_v1_frame_parser_defines.svh
// Assertion macros for the MSP v1 frame parser RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef MSP_V1_FRAME_PARSER_DEFINES_SVH
`define MSP_V1_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checks disabled while reset is asserted.
`define MSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checks disabled while reset is asserted.
`define MSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/msp_fp_pkg.sv
// Types and constants for the MSP v1 frame parser.
// No dependencies; imported by msp_v1_frame_parser and the testbench.
package msp_fp_pkg;

	// Header characters
	localparam logic [7:0] CH_START = 8'h24;	// '$'
	localparam logic [7:0] CH_M     = 8'h4D;	// 'M'
	localparam logic [7:0] CH_DIR   = 8'h3E;	// '>'

	// Result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_GOOD = 2'd1;
	localparam logic [1:0] KIND_BAD  = 2'd2;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_M     = 3'd1,
		PH_DIR   = 3'd2,
		PH_SIZE  = 3'd3,
		PH_CMD   = 3'd4,
		PH_DATA  = 3'd5,
		PH_CHECK = 3'd6
	} phase_t;

endpackage

### rtl/msp_v1_frame_parser.sv
// MSP v1 reply deframer with XOR checksum: top level, single module.
// Depends on msp_fp_pkg and msp_v1_frame_parser_defines.svh.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid, in_stall, rx_byte                    | sink
//  out     | out_valid, out_stall, kind, data_byte,         | source
//          | command_id, byte_index                         |
//
// One byte per cycle sustained while out is not stalled. A byte is first
// registered in the input register (_s1), then the parse step and the XOR
// run in one pass from _s1 into the result register.
// Header, size and command bytes leave no result and never wait on out.
// Reset (arst_n low) clears both valid flags and puts the parser in the
// hunt for '$'. A stall on out holds the result register; in stalls only
// when the byte in _s1 has a result that cannot yet be written.
`include "msp_v1_frame_parser_defines.svh"

module msp_v1_frame_parser
	import msp_fp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] command_id,
	output logic [7:0] byte_index
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	phase_t     phase_q, phase_d;
	logic [7:0] frame_length_q, frame_length_d;
	logic [7:0] bytes_seen_q, bytes_seen_d;
	logic [7:0] running_check_q, running_check_d;
	logic [7:0] frame_command_q, frame_command_d;

	// result register
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_byte_q, command_id_q, byte_index_q;

	logic       has_result;
	logic       out_free;
	logic       s1_go;
	logic       in_xfer;
	logic [1:0] res_kind;
	logic [7:0] res_index;
	logic [8:0] seen_next;

	assign out_free   = !out_valid_q || !out_stall;
	assign has_result = (phase_q == PH_DATA) || (phase_q == PH_CHECK);
	// the byte in _s1 is consumed now; header bytes need no output slot
	assign s1_go      = valid_s1 && (!has_result || out_free);
	assign in_stall   = valid_s1 && !s1_go;
	assign in_xfer    = in_valid && !in_stall;
	assign seen_next  = {1'b0, bytes_seen_q} + 9'd1;

	// next state and result for the byte in _s1
	always_comb begin
		phase_d         = phase_q;
		frame_length_d  = frame_length_q;
		bytes_seen_d    = bytes_seen_q;
		running_check_d = running_check_q;
		frame_command_d = frame_command_q;
		res_kind        = KIND_DATA;
		res_index       = bytes_seen_q;
		case (phase_q)
			PH_M: begin
				phase_d = (byte_s1 == CH_M) ? PH_DIR : PH_START;
			end
			PH_DIR: begin
				phase_d = (byte_s1 == CH_DIR) ? PH_SIZE : PH_START;
			end
			PH_SIZE: begin
				frame_length_d  = byte_s1;
				running_check_d = byte_s1;
				bytes_seen_d    = '0;
				phase_d         = PH_CMD;
			end
			PH_CMD: begin
				frame_command_d = byte_s1;
				running_check_d = running_check_q ^ byte_s1;
				// empty payload skips straight to the checksum
				phase_d = (frame_length_q != '0) ? PH_DATA : PH_CHECK;
			end
			PH_DATA: begin
				running_check_d = running_check_q ^ byte_s1;
				if (seen_next >= {1'b0, frame_length_q}) begin
					phase_d = PH_CHECK;
				end
				bytes_seen_d = seen_next[7:0];
			end
			PH_CHECK: begin
				res_kind  = (byte_s1 == running_check_q) ? KIND_GOOD : KIND_BAD;
				res_index = frame_length_q;
				phase_d   = PH_START;
			end
			default: begin
				// hunt for '$'; the unused code behaves the same
				phase_d = (byte_s1 == CH_START) ? PH_M : PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_START;
			frame_length_q  <= '0;
			bytes_seen_q    <= '0;
			running_check_q <= '0;
			frame_command_q <= '0;
		end else if (s1_go) begin
			phase_q         <= phase_d;
			frame_length_q  <= frame_length_d;
			bytes_seen_q    <= bytes_seen_d;
			running_check_q <= running_check_d;
			frame_command_q <= frame_command_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && has_result) begin
			kind_q       <= res_kind;
			data_byte_q  <= byte_s1;
			command_id_q <= frame_command_q;
			byte_index_q <= res_index;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign data_byte  = data_byte_q;
	assign command_id = command_id_q;
	assign byte_index = byte_index_q;

	// checks
	`MSP_ASSERT_NEXT(a_check_rehunts, clk, arst_n, s1_go && (phase_q == PH_CHECK), phase_q == PH_START, "parser did not return to hunt after checksum")
	`MSP_ASSERT_NOW(a_index_below_len, clk, arst_n, phase_q == PH_DATA, bytes_seen_q < frame_length_q, "payload index reached frame length")
	`MSP_ASSERT_NOW(a_kind_legal, clk, arst_n, out_valid_q, kind_q <= KIND_BAD, "illegal result kind")

endmodule

### verif/msp_fp_tb_pkg.sv
`timescale 1ns / 100ps
// Deframing tracker for the MSP v1 frame parser testbench: predicts results from the
// bytes taken in and checks each delivered result against them. Depends on msp_fp_pkg.
package msp_fp_tb_pkg;
	import msp_fp_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [7:0] command_id;
		logic [7:0] byte_index;
	} frame_item_t;

	class deframe_tracker;
		phase_t      phase;
		logic [7:0]  frame_len;
		logic [7:0]  payload_seen;
		logic [7:0]  xor_sum;
		logic [7:0]  frame_cmd;
		frame_item_t pending_results[$];
		int unsigned n_errors;

		function new();
			phase        = PH_START;
			frame_len    = 8'd0;
			payload_seen = 8'd0;
			xor_sum      = 8'd0;
			frame_cmd    = 8'd0;
			n_errors     = 0;
		endfunction

		function void report(string what, frame_item_t exp_item, frame_item_t got_item);
			if (n_errors < 10) begin
				$display("%0t ns: %s exp kind=%0d data=%02h cmd=%02h idx=%0d", $time, what,
					exp_item.kind, exp_item.data_byte, exp_item.command_id,
					exp_item.byte_index);
				$display("      got kind=%0d data=%02h cmd=%02h idx=%0d", got_item.kind,
					got_item.data_byte, got_item.command_id, got_item.byte_index);
			end
			n_errors++;
		endfunction

		// one accepted byte: advance the parse and queue any result it causes
		function void take_byte(logic [7:0] b);
			frame_item_t r;
			case (phase)
				PH_M: phase = (b == CH_M) ? PH_DIR : PH_START;
				PH_DIR: phase = (b == CH_DIR) ? PH_SIZE : PH_START;
				PH_SIZE: begin
					frame_len    = b;
					xor_sum      = b;
					payload_seen = 8'd0;
					phase        = PH_CMD;
				end
				PH_CMD: begin
					frame_cmd = b;
					xor_sum   = xor_sum ^ b;
					phase     = (frame_len != 8'd0) ? PH_DATA : PH_CHECK;
				end
				PH_DATA: begin
					r.kind       = KIND_DATA;
					r.data_byte  = b;
					r.command_id = frame_cmd;
					r.byte_index = payload_seen;
					pending_results = {pending_results, r};
					xor_sum = xor_sum ^ b;
					if ({1'b0, payload_seen} + 9'd1 >= {1'b0, frame_len})
						phase = PH_CHECK;
					payload_seen = payload_seen + 8'd1;
				end
				PH_CHECK: begin
					r.kind       = (b == xor_sum) ? KIND_GOOD : KIND_BAD;
					r.data_byte  = b;
					r.command_id = frame_cmd;
					r.byte_index = frame_len;
					pending_results = {pending_results, r};
					phase = PH_START;
				end
				default: phase = (b == CH_START) ? PH_M : PH_START;
			endcase
		endfunction

		function void check_result(logic [1:0] k, logic [7:0] d, logic [7:0] c,
				logic [7:0] i);
			frame_item_t got_item;
			frame_item_t exp_item;
			got_item = '{kind: k, data_byte: d, command_id: c, byte_index: i};
			if (pending_results.size() == 0) begin
				report("unexpected result:", '0, got_item);
			end else begin
				exp_item = pending_results.pop_front();
				if (got_item.kind != exp_item.kind || got_item.data_byte != exp_item.data_byte
						|| got_item.command_id != exp_item.command_id
						|| got_item.byte_index != exp_item.byte_index)
					report("wrong result:", exp_item, got_item);
			end
		endfunction

		function int unsigned outstanding();
			return pending_results.size();
		endfunction

		// anything still queued at the end never arrived
		function void flag_leftovers();
			while (pending_results.size() != 0)
				report("missing result:", pending_results.pop_front(), '0);
		endfunction
	endclass

endpackage

### verif/msp_v1_frame_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top for msp_v1_frame_parser: drives byte streams, checks results.
// Depends on msp_fp_pkg, msp_fp_tb_pkg and the parser RTL.
module msp_v1_frame_parser_tb;
	import msp_fp_pkg::*;
	import msp_fp_tb_pkg::*;

	localparam int unsigned RANDOM_BYTES = 850;
	localparam int unsigned HOLD_CYCLES  = 80;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] command_id;
	logic [7:0] byte_index;

	deframe_tracker tracker = new();

	// idle rates in percent, changed by the stimulus as the run moves on
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	// one-shot request for a long back-pressure stretch on the result side
	bit          hold_req     = 1'b0;
	// every byte transferred so far, directed part included
	int unsigned sent_bytes   = 0;

	msp_v1_frame_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.command_id (command_id),
		.byte_index (byte_index)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run (about RANDOM_BYTES bytes,
	// sent at heavy idling on both sides).
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Offer one byte, then wait for its transfer. Inputs only change at rising
	// edges, so in_stall sampled at the falling edge is what the next rising
	// edge sees. Returns at the edge on which the transfer happened.
	task automatic send_byte(input logic [7:0] b);
		bit taken;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		tracker.take_byte(b);
		sent_bytes++;
	endtask

	// Complete reply frame with random payload; bad_sum spoils the checksum.
	task automatic send_frame(input int unsigned len, input logic [7:0] cmd,
			input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] d;
		send_byte(CH_START);
		send_byte(CH_M);
		send_byte(CH_DIR);
		send_byte(len[7:0]);
		sum = len[7:0];
		send_byte(cmd);
		sum = sum ^ cmd;
		for (int unsigned i = 0; i < len; i++) begin
			d = 8'($urandom_range(255));
			sum = sum ^ d;
			send_byte(d);
		end
		if (bad_sum)
			sum = sum ^ 8'($urandom_range(255, 1));
		send_byte(sum);
	endtask

	// Header that breaks off part way, sometimes on a fresh '$'.
	task automatic send_broken_header();
		logic [7:0] junk;
		send_byte(CH_START);
		if ($urandom_range(1))
			send_byte(CH_M);
		junk = $urandom_range(1) ? CH_START : 8'($urandom_range(255));
		if (junk == CH_M || junk == CH_DIR)
			junk = ~junk;
		send_byte(junk);
	endtask

	task automatic send_noise(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	// Result side: random stall, or a long hold-off when asked for.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < snk_idle_pct);
			end
		end
	end

	// Result monitor: a transfer at the next rising edge is fully decided by
	// the falling edge before it, so sample and check there.
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall)
				tracker.check_result(kind, data_byte, command_id, byte_index);
		end
	end

	initial begin
		int unsigned waited;
		int unsigned pick;
		int unsigned len;
		bit          hold_done;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		rx_byte   <= 8'h00;
		out_stall <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// empty payload, command 0, good checksum of zero
		send_byte(CH_START); send_byte(CH_M); send_byte(CH_DIR);
		send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
		// '$' while waiting for 'M', then '$' while waiting for '>'
		send_byte(CH_START); send_byte(CH_START); send_byte(CH_M);
		send_byte(CH_START); send_byte(CH_M); send_byte(CH_START);
		// two-byte payload at the byte extremes, command 0xFF, good checksum
		send_byte(CH_START); send_byte(CH_M); send_byte(CH_DIR);
		send_byte(8'h02); send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF);
		send_byte(8'h02);
		// empty payload with a wrong checksum
		send_byte(CH_START); send_byte(CH_M); send_byte(CH_DIR);
		send_byte(8'h00); send_byte(8'h7F); send_byte(8'h00);

		// --- random part ---
		// sender idles lightly and receiver heavily, then the reverse, then
		// no idling at all with one long hold-off on the result side
		hold_done = 1'b0;
		src_idle_pct = 35;
		snk_idle_pct = 73;
		// largest frame once: byte_index runs to 254, length 255 at the end
		send_frame(255, 8'($urandom_range(255)), 1'($urandom_range(1)));
		while (sent_bytes < RANDOM_BYTES) begin
			if (sent_bytes >= 2 * RANDOM_BYTES / 3) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
				if (!hold_done) begin
					hold_done = 1'b1;
					hold_req  = 1'b1;
					// keep payload flowing while the results back up
					send_frame(40, 8'($urandom_range(255)), 1'b0);
				end
			end else if (sent_bytes >= RANDOM_BYTES / 3) begin
				src_idle_pct = 73;
				snk_idle_pct = 35;
			end
			pick = $urandom_range(99);
			if (pick < 72) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(60, 9) : $urandom_range(6);
				send_frame(len, 8'($urandom_range(255)), $urandom_range(4) == 0);
			end else if (pick < 84) begin
				send_broken_header();
			end else begin
				send_noise($urandom_range(6, 1));
			end
		end
		in_valid <= 1'b0;

		// drain, then keep watching for a while for any stray result
		waited = 0;
		while (tracker.outstanding() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		tracker.flag_leftovers();

		if (tracker.n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
